### sv/qpe_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qpe_pkg
// Shared types and constants of the query parameter extractor.
// ---------------------------------------------------------------------------
package qpe_pkg;

   localparam int unsigned MAX_NAME_BYTES_DEF = 16;
   localparam int unsigned NAME_BYTES_W       = 128;
   localparam int unsigned NAME_LENGTH_W      = 5;
   localparam int unsigned CSR_DATA_W         = 64;
   localparam int unsigned CSR_INDEX_W        = 2;

   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_AMP   = 8'h26;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NAME_LOW    = 2'd0,
      CSR_NAME_HIGH   = 2'd1,
      CSR_NAME_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_VALUE     = 2'd0,
      KIND_FOUND     = 2'd1,
      KIND_NOT_FOUND = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      MODE_COMPARE = 4'b0001,
      MODE_SKIP    = 4'b0010,
      MODE_VALUE   = 4'b0100,
      MODE_DONE    = 4'b1000
   } scan_mode_type;

   typedef struct packed {
      logic [NAME_BYTES_W-1:0]  name_bytes;
      logic [NAME_LENGTH_W-1:0] name_length;
   } name_cfg_type;

   typedef struct packed {
      logic [7:0] value_byte;
      kind_type   kind;
      logic       run_last;
   } result_type;

endpackage : qpe_pkg
`default_nettype wire

### sv/qpe_csr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qpe_csr
// Configuration registers holding the parameter name and its length.
// ---------------------------------------------------------------------------
module qpe_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [qpe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [qpe_pkg::CSR_DATA_W-1:0]      csr_data,
   output qpe_pkg::name_cfg_type                    name_cfg
);
   import qpe_pkg::*;

   logic [CSR_DATA_W-1:0]    name_low_ff, name_low_in;
   logic [CSR_DATA_W-1:0]    name_high_ff, name_high_in;
   logic [NAME_LENGTH_W-1:0] name_length_ff, name_length_in;
   csr_index_type            index;

   assign csr_ready = 1'b1;
   assign index     = csr_index_type'(csr_index);

   always_comb begin
      name_low_in    = name_low_ff;
      name_high_in   = name_high_ff;
      name_length_in = name_length_ff;
      if (csr_valid && csr_ready) begin
         unique case (index)
            CSR_NAME_LOW:    name_low_in    = csr_data;
            CSR_NAME_HIGH:   name_high_in   = csr_data;
            CSR_NAME_LENGTH: name_length_in = csr_data[NAME_LENGTH_W-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_low_ff    <= '0;
         name_high_ff   <= '0;
         name_length_ff <= '0;
      end else begin
         name_low_ff    <= name_low_in;
         name_high_ff   <= name_high_in;
         name_length_ff <= name_length_in;
      end
   end

   assign name_cfg.name_bytes  = {name_high_ff, name_low_ff};
   assign name_cfg.name_length = name_length_ff;

endmodule : qpe_csr
`default_nettype wire

### sv/qpe_scan.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qpe_scan
// Field scanner: compares each field against the name and decides results.
// ---------------------------------------------------------------------------
module qpe_scan #(
   parameter int unsigned MaxNameBytes = qpe_pkg::MAX_NAME_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  end_mark,
   input  wire qpe_pkg::name_cfg_type name_cfg,
   output logic                       result_valid,
   output qpe_pkg::result_type        result
);
   import qpe_pkg::*;

   localparam int unsigned PosW = $clog2(MaxNameBytes + 1);
   localparam logic [NAME_LENGTH_W-1:0] MaxLen = NAME_LENGTH_W'(MaxNameBytes);

   scan_mode_type            mode_ff, mode_in;
   logic [PosW-1:0]          pos_ff, pos_in;
   logic [PosW-1:0]          len;
   logic [NAME_LENGTH_W-1:0] pos_ext;
   logic [7:0]               name_byte;
   logic                     at_len;

   assign len = (name_cfg.name_length > MaxLen) ? PosW'(MaxLen)
                                                : PosW'(name_cfg.name_length);
   assign pos_ext   = NAME_LENGTH_W'(pos_ff);
   assign name_byte = name_cfg.name_bytes[pos_ext[3:0]*8 +: 8];
   assign at_len    = (pos_ff == len);

   always_comb begin
      mode_in             = mode_ff;
      pos_in              = pos_ff;
      result_valid        = 1'b0;
      result.value_byte   = '0;
      result.kind         = KIND_VALUE;
      result.run_last     = 1'b0;
      if (accept) begin
         if (end_mark) begin
            mode_in = MODE_COMPARE;
            pos_in  = '0;
            if (mode_ff == MODE_VALUE || (mode_ff == MODE_COMPARE && at_len)) begin
               result_valid    = 1'b1;
               result.kind     = KIND_FOUND;
               result.run_last = 1'b1;
            end else if (mode_ff != MODE_DONE) begin
               result_valid    = 1'b1;
               result.kind     = KIND_NOT_FOUND;
               result.run_last = 1'b1;
            end
         end else begin
            unique case (mode_ff)
               MODE_COMPARE: begin
                  priority if (data_byte == CHAR_AMP) begin
                     if (at_len) begin
                        result_valid    = 1'b1;
                        result.kind     = KIND_FOUND;
                        result.run_last = 1'b1;
                        mode_in         = MODE_DONE;
                     end
                     pos_in = '0;
                  end else if (pos_ff >= len) begin
                     mode_in = (data_byte == CHAR_EQUAL) ? MODE_VALUE : MODE_SKIP;
                  end else if (data_byte == name_byte) begin
                     pos_in = pos_ff + 1'b1;
                  end else begin
                     mode_in = MODE_SKIP;
                  end
               end
               MODE_SKIP: begin
                  if (data_byte == CHAR_AMP) begin
                     mode_in = MODE_COMPARE;
                     pos_in  = '0;
                  end
               end
               MODE_VALUE: begin
                  result_valid = 1'b1;
                  if (data_byte == CHAR_AMP) begin
                     result.kind     = KIND_FOUND;
                     result.run_last = 1'b1;
                     mode_in         = MODE_DONE;
                  end else begin
                     result.value_byte = data_byte;
                  end
               end
               MODE_DONE: ;
               default: begin
                  mode_in = MODE_COMPARE;
                  pos_in  = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COMPARE;
         pos_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

   // The end marker always brings the scanner back to the start of a field.
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && end_mark |=> mode_ff == MODE_COMPARE && pos_ff == '0)
      else $error("scanner did not restart after end marker");

   // Terminal results carry run_last, value bytes do not.
   a_last_on_terminal: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (result.run_last == (result.kind != KIND_VALUE)))
      else $error("run_last disagrees with result kind");

   // The name position never runs past the effective name length.
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_COMPARE |-> pos_ff <= len)
      else $error("name position beyond name length");

endmodule : qpe_scan
`default_nettype wire

### sv/qpe_outbuf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qpe_outbuf
// Result register with a skid stage; the input stalls only when both fill.
// ---------------------------------------------------------------------------
module qpe_outbuf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire qpe_pkg::result_type push_data,
   output logic                     full,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output qpe_pkg::result_type      out_data
);
   import qpe_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take;

   assign take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // The skid stage only holds data while the result register is occupied.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage filled while result register empty");

   // The skid stage fills only when a held result was stalled.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && skid_valid_in |-> out_valid_ff && out_stall && push)
      else $error("skid stage filled without a stalled result");

   // No push arrives while both stages are full.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("transaction pushed into a full buffer");

endmodule : qpe_outbuf
`default_nettype wire

### sv/query_parameter_extractor_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// query_parameter_extractor_core
// Extracts the value of one named parameter from a byte-wide query string.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Transaction
//  req_     in         req_valid/req_stall  one string byte or the end marker
//  rsp_     out        rsp_valid/rsp_stall  value byte, found or not found
//  csr_     in         csr_valid/csr_ready  write of one name register
//
// One request transaction is taken per clock unless req_stall is high; its
// result, if any, is registered in the result register or the skid stage.
// The scan state updates in the same cycle that the transaction is accepted.
// A result register plus a skid stage absorb a stalled response; req_stall
// rises only when both hold a pending transaction.
// Reset is synchronous and clears the scan state, the name registers and
// the output buffer.
// ---------------------------------------------------------------------------
module query_parameter_extractor_core #(
   parameter int unsigned MaxNameBytes = qpe_pkg::MAX_NAME_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic                            req_end_mark,
   // Response channel.
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_value_byte,
   output qpe_pkg::kind_type                    rsp_kind,
   output logic                                 rsp_run_last,
   // Configuration write channel.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [qpe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [qpe_pkg::CSR_DATA_W-1:0]  csr_data
);
   import qpe_pkg::*;

   name_cfg_type name_cfg;
   logic         accept;
   logic         result_valid;
   result_type   result;
   result_type   rsp_data;
   logic         buf_full;

   // A request transaction is accepted whenever the skid stage is free.
   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   qpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .name_cfg  (name_cfg)
   );

   // The scanner decides, in the accept cycle, whether this byte produces
   // a value byte, a terminal result, or nothing at all.
   qpe_scan #(
      .MaxNameBytes (MaxNameBytes)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .end_mark     (req_end_mark),
      .name_cfg     (name_cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   // Results land in the result register, or in the skid stage when the
   // result register is holding a stalled transaction.
   qpe_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_value_byte = rsp_data.value_byte;
   assign rsp_kind       = rsp_data.kind;
   assign rsp_run_last   = rsp_data.run_last;

endmodule : query_parameter_extractor_core
`default_nettype wire

### tb/sv/tb_query_parameter_extractor_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_query_parameter_extractor_core
// Self-checking bench for the query parameter extractor core. Query strings
// are streamed into the request channel under random idle gaps and random
// response stalls. A scan model inside the bench predicts every value byte
// and every found / not-found verdict. The monitor compares each response
// against the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module tb_query_parameter_extractor_core;
   import qpe_pkg::*;

   localparam int unsigned NAME_MAX = MAX_NAME_BYTES_DEF;
   // Register index that the core must ignore.
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 2000;
   localparam int unsigned PHASE_ITEMS = 150;
   // Cycles to let the core settle after the last expected response.
   localparam int unsigned DRAIN_CYCLES = 8;

   // One request transaction: a string byte or the end marker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_mark;
   } string_item_type;

   // Shapes of the fields that the random strings are built from.
   typedef enum int unsigned {
      FIELD_WITH_VALUE,
      FIELD_BARE_NAME,
      FIELD_PREFIX,
      FIELD_LONGER_NAME,
      FIELD_MIXED,
      FIELD_NOISE
   } field_shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   req_end_mark = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_value_byte;
   kind_type               rsp_kind;
   logic                   rsp_run_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Bytes waiting for the driver, and responses the scan model expects.
   string_item_type pending_bytes[$];
   result_type      expected_results[$];

   // Scan model state and its copy of the name registers.
   scan_mode_type scan_state = MODE_COMPARE;
   logic [4:0]    name_matched = 5'd0;
   logic [63:0]   cfg_name_low = 64'd0;
   logic [63:0]   cfg_name_high = 64'd0;
   logic [4:0]    cfg_name_length = 5'd0;

   // Name that the stimulus currently targets.
   logic [7:0]  name_buf [16];
   int unsigned name_len = 0;

   int unsigned items_queued = 0;
   int unsigned error_count = 0;
   int unsigned req_hold_off = 0;
   int unsigned rsp_hold = 0;
   bit          req_no_idle = 1'b0;
   bit          rsp_no_idle = 1'b0;

   query_parameter_extractor_core #(
      .MaxNameBytes(NAME_MAX)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_end_mark  (req_end_mark),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_byte(rsp_value_byte),
      .rsp_kind      (rsp_kind),
      .rsp_run_last  (rsp_run_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is bounded no matter what the core does.
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Wait cycles before the next transaction on one side. Now and then the
   // side toggles into a stretch where it never idles at all.
   function automatic int unsigned draw_wait(inout bit no_idle);
      if ($urandom_range(0, 39) == 0) begin
         no_idle = !no_idle;
      end
      return no_idle ? 0 : $urandom_range(0, 5);
   endfunction

   // Scan model: advances on one accepted request transaction and queues the
   // response that it must cause, if any.
   function automatic void predict_scan(input logic [7:0] b, input logic end_mark);
      logic [4:0]   eff_len;
      logic [127:0] name_all;
      result_type   r;
      // A length above the maximum is taken as the maximum.
      eff_len = (cfg_name_length > NAME_MAX) ? 5'(NAME_MAX) : cfg_name_length;
      name_all = {cfg_name_high, cfg_name_low};
      r.value_byte = 8'h00;
      r.kind = KIND_FOUND;
      r.run_last = 1'b1;
      if (end_mark) begin
         // A bare name still being compared at the end counts as found.
         if (scan_state == MODE_VALUE ||
             (scan_state == MODE_COMPARE && name_matched == eff_len)) begin
            expected_results.push_back(r);
         end else if (scan_state != MODE_DONE) begin
            r.kind = KIND_NOT_FOUND;
            expected_results.push_back(r);
         end
         scan_state = MODE_COMPARE;
         name_matched = 5'd0;
      end else begin
         case (scan_state)
            MODE_COMPARE: begin
               if (b == CHAR_AMP) begin
                  if (name_matched == eff_len) begin
                     expected_results.push_back(r);
                     scan_state = MODE_DONE;
                  end
                  name_matched = 5'd0;
               end else if (name_matched >= eff_len) begin
                  scan_state = (b == CHAR_EQUAL) ? MODE_VALUE : MODE_SKIP;
               end else if (b == name_all[name_matched[3:0]*8 +: 8]) begin
                  name_matched++;
               end else begin
                  scan_state = MODE_SKIP;
               end
            end
            MODE_SKIP: begin
               if (b == CHAR_AMP) begin
                  scan_state = MODE_COMPARE;
                  name_matched = 5'd0;
               end
            end
            MODE_VALUE: begin
               if (b == CHAR_AMP) begin
                  expected_results.push_back(r);
                  scan_state = MODE_DONE;
               end else begin
                  r.value_byte = b;
                  r.kind = KIND_VALUE;
                  r.run_last = 1'b0;
                  expected_results.push_back(r);
               end
            end
            default: begin
            end
         endcase
      end
   endfunction

   // Request driver. The payload is only changed when the current transaction
   // has been accepted or nothing is offered, so a stalled payload holds.
   always @(posedge clock) begin
      string_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         req_hold_off <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_scan(req_data_byte, req_end_mark);
         end
         if (!req_valid || !req_stall) begin
            if (req_hold_off != 0) begin
               req_valid <= 1'b0;
               req_hold_off <= req_hold_off - 1;
            end else if (pending_bytes.size() != 0) begin
               next_item = pending_bytes.pop_front();
               req_data_byte <= next_item.data_byte;
               req_end_mark <= next_item.end_mark;
               req_valid <= 1'b1;
               // Gap that follows this transaction before the next one.
               req_hold_off <= draw_wait(req_no_idle);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. After each accepted response the stall line is held
   // high for a random wait, which may be zero, whether or not more is waiting.
   always @(posedge clock) begin
      result_type  want;
      int unsigned w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response kind=%s byte=%02h",
                                      rsp_kind.name(), rsp_value_byte));
         end else begin
            want = expected_results.pop_front();
            if (rsp_kind !== want.kind) begin
               report_mismatch($sformatf("kind %s, expected %s",
                                         rsp_kind.name(), want.kind.name()));
            end
            if (rsp_value_byte !== want.value_byte) begin
               report_mismatch($sformatf("value_byte %02h, expected %02h",
                                         rsp_value_byte, want.value_byte));
            end
            if (rsp_run_last !== want.run_last) begin
               report_mismatch($sformatf("run_last %b, expected %b",
                                         rsp_run_last, want.run_last));
            end
         end
         w = draw_wait(rsp_no_idle);
         rsp_stall <= (w != 0);
         rsp_hold <= (w != 0) ? w - 1 : 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // One register write. The write lands at the edge where valid and ready
   // are both high; the scan model takes the new value at that point.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NAME_LOW:    cfg_name_low = data;
         CSR_NAME_HIGH:   cfg_name_high = data;
         CSR_NAME_LENGTH: cfg_name_length = data[4:0];
         default: begin
         end
      endcase
   endtask

   // Writes name_buf and name_len to the core. The bits of the length word
   // above the length field carry junk that the core must drop.
   task automatic load_name(input logic [58:0] junk);
      logic [63:0] low_word;
      logic [63:0] high_word;
      for (int i = 0; i < 8; i++) begin
         low_word[i*8 +: 8] = name_buf[i];
         high_word[i*8 +: 8] = name_buf[i + 8];
      end
      csr_write(CSR_NAME_LOW, low_word);
      csr_write(CSR_NAME_HIGH, high_word);
      csr_write(CSR_NAME_LENGTH, {junk, 5'(name_len)});
   endtask

   task automatic set_name(input string s);
      for (int i = 0; i < 16; i++) begin
         name_buf[i] = (i < s.len()) ? s[i] : 8'h00;
      end
      name_len = s.len();
   endtask

   task automatic push_byte(input logic [7:0] b);
      string_item_type it;
      it.data_byte = b;
      it.end_mark = 1'b0;
      pending_bytes.push_back(it);
      items_queued++;
   endtask

   // The byte lane of an end marker is don't-care, so it gets random junk.
   task automatic push_end();
      string_item_type it;
      it.data_byte = 8'($urandom());
      it.end_mark = 1'b1;
      pending_bytes.push_back(it);
      items_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i]);
      end
   endtask

   task automatic push_name(input int unsigned n);
      for (int i = 0; i < n; i++) begin
         push_byte(name_buf[i]);
      end
   endtask

   function automatic logic [7:0] value_rand();
      logic [7:0] b;
      do b = 8'($urandom()); while (b == CHAR_AMP);
      return b;
   endfunction

   // Bytes drawn from the name, the separators and random noise.
   function automatic logic [7:0] mixed_byte();
      case ($urandom_range(0, 3))
         0: return name_buf[$urandom_range(0, 15)];
         1: return CHAR_EQUAL;
         2: return CHAR_AMP;
         default: return 8'($urandom());
      endcase
   endfunction

   // Builds one query string out of a few fields of random shape, mostly
   // around the configured name so that matches are common, then ends it.
   task automatic push_random_string();
      int unsigned     n_fields;
      int unsigned     eff;
      int unsigned     pick;
      field_shape_type shape;
      logic [7:0]      b;
      eff = (name_len > NAME_MAX) ? NAME_MAX : name_len;
      n_fields = $urandom_range(0, 4);
      for (int f = 0; f < n_fields; f++) begin
         if (f != 0) begin
            push_byte(CHAR_AMP);
         end
         pick = $urandom_range(0, 9);
         shape = (pick < 3) ? FIELD_WITH_VALUE :
                 (pick == 3) ? FIELD_BARE_NAME :
                 (pick == 4) ? FIELD_PREFIX :
                 (pick == 5) ? FIELD_LONGER_NAME :
                 (pick < 8) ? FIELD_MIXED : FIELD_NOISE;
         case (shape)
            FIELD_WITH_VALUE: begin
               push_name(eff);
               push_byte(CHAR_EQUAL);
               repeat ($urandom_range(0, 5)) push_byte(value_rand());
            end
            FIELD_BARE_NAME: push_name(eff);
            FIELD_PREFIX: begin
               push_name($urandom_range(0, eff));
               repeat ($urandom_range(0, 3)) push_byte(mixed_byte());
            end
            FIELD_LONGER_NAME: begin
               push_name(eff);
               do b = value_rand(); while (b == CHAR_EQUAL);
               push_byte(b);
            end
            FIELD_MIXED: repeat ($urandom_range(1, 6)) push_byte(mixed_byte());
            default: repeat ($urandom_range(0, 6)) push_byte(8'($urandom()));
         endcase
      end
      // A trailing separator leaves an empty last field.
      if ($urandom_range(0, 7) == 0) begin
         push_byte(CHAR_AMP);
      end
      push_end();
   endtask

   // Waits until every queued byte is accepted and every expected response
   // is checked, then lets the core settle before any register is touched.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus: a short directed part, then random phases. Each phase writes
   // a new name while the core is idle and streams strings against it.
   initial begin
      int unsigned phase_idx;
      int unsigned phase_end;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Value bytes at both extremes, then found on the closing separator;
      // the bytes after it and the end marker cause nothing more.
      set_name("ab");
      load_name('0);
      push_text("ab=");
      push_byte(8'h00);
      push_byte(8'hFF);
      push_text("&x");
      push_end();
      // The name alone, with no value, is found at the end marker.
      push_text("ab");
      push_end();
      // An empty string reports not found.
      push_end();
      wait_idle();

      // The empty name matches a field that starts with the equals sign.
      set_name("");
      load_name('0);
      push_text("=q");
      push_end();
      wait_idle();

      // A name holding a separator can never match.
      set_name("a&");
      load_name('0);
      push_text("a&");
      push_end();
      wait_idle();

      // Random phases. The first ones pin the length extremes: a full name,
      // an oversized length that must be clamped, and the empty name.
      items_queued = 0;
      phase_idx = 0;
      while (items_queued < RANDOM_ITEMS) begin
         for (int i = 0; i < 16; i++) begin
            name_buf[i] = 8'($urandom());
            if (name_buf[i] == CHAR_AMP) begin
               name_buf[i] = 8'h61;
            end
         end
         case (phase_idx)
            0: name_len = NAME_MAX;
            1: name_len = 31;
            2: name_len = 0;
            default: begin
               case ($urandom_range(0, 7))
                  0: name_len = 0;
                  1: name_len = $urandom_range(NAME_MAX, 31);
                  default: name_len = $urandom_range(1, 8);
               endcase
            end
         endcase
         load_name(59'({$urandom(), $urandom()}));
         if (phase_idx == 0) begin
            csr_write(CSR_INDEX_UNUSED, {$urandom(), $urandom()});
         end
         phase_end = items_queued + PHASE_ITEMS;
         while (items_queued < phase_end) begin
            push_random_string();
         end
         wait_idle();
         phase_idx++;
      end

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
sv/qpe_pkg.sv
sv/qpe_csr.sv
sv/qpe_scan.sv
sv/qpe_outbuf.sv
sv/query_parameter_extractor_core.sv
tb/sv/tb_query_parameter_extractor_core.sv
